@@ hdl/aes_pkg.sv @@
// Package for the AES-128 block encryption pipeline.
// Holds payload structs, register indexes, the S-box and GF(2^8) helpers.
// No dependencies.
package aes_pkg;

    typedef struct packed {
        logic [63:0] block_high;
        logic [63:0] block_low;
    } in_item_t;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
    } out_item_t;

    localparam logic REG_KEY_HIGH = 1'b0;
    localparam logic REG_KEY_LOW  = 1'b1;

    localparam int unsigned NUM_ROUNDS = 10;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON [10] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    // multiply by x in GF(2^8), reducing by the AES polynomial
    function automatic logic [7:0] gf_double(input logic [7:0] x);
        gf_double = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a 128-bit block, byte 0 most significant
    function automatic logic [7:0] get_byte(input logic [127:0] s, input int unsigned i);
        get_byte = s[127 - 8*i -: 8];
    endfunction

    // one round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey
    function automatic logic [127:0] enc_round(input logic [127:0] s, input logic [127:0] rk,
                                               input logic mix);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
        logic [127:0] res;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[4*c + r] = SBOX[get_byte(s, 4*((c + r) % 4) + r)];
        for (int c = 0; c < 4; c++)
        begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            d0 = gf_double(a0); d1 = gf_double(a1);
            d2 = gf_double(a2); d3 = gf_double(a3);
            if (mix)
            begin
                t[4*c]   = d0 ^ d1 ^ a1 ^ a2 ^ a3;
                t[4*c+1] = a0 ^ d1 ^ d2 ^ a2 ^ a3;
                t[4*c+2] = a0 ^ a1 ^ d2 ^ d3 ^ a3;
                t[4*c+3] = d0 ^ a0 ^ a1 ^ a2 ^ d3;
            end
        end
        for (int i = 0; i < 16; i++)
            res[127 - 8*i -: 8] = t[i];
        enc_round = res ^ rk;
    endfunction

    // next round key from the previous one
    function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
        t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        next_key = {w0, w1, w2, w3};
    endfunction

endpackage

@@ hdl/aes128_block_encrypt.sv @@
// AES-128 encryption pipeline top level: one round per register stage.
// Depends on aes_pkg.
//
// Usage:
//   Input channel (in_valid, in_stall, in_data) carries one plaintext block per
//   transaction; output channel (out_valid, out_stall, out_data) one ciphertext.
//   A transaction moves at a clock edge with valid high and stall low.
//   Key is written on cfg_we/cfg_index/cfg_data: index 0 key bytes 0-7,
//   index 1 key bytes 8-15. Write the key only while the pipeline is empty.
//   Round keys ripple through rk_reg[1..10] after a key write, in step with the
//   first block behind it, so a block may follow the write in the next cycle.
//   Stages: initial AddRoundKey stage plus ten round stages, the last being
//   the output register. Throughput: one block per cycle while in_stall is
//   low; each round stage holds one block and its S-box/MixColumns logic
//   sets the clock period.
//   When the receiver stalls, the output stage holds and bubbles are squeezed
//   out; in_stall rises only while the output stage is full and stalled.
//   Reset clears valid bits and the key to zero; round keys recompute from it.
module aes128_block_encrypt (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  aes_pkg::in_item_t in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output aes_pkg::out_item_t out_data,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [63:0]       cfg_data
);

    localparam int unsigned NS = aes_pkg::NUM_ROUNDS + 1;

    logic [127:0] key_reg;
    logic [127:0] rk_reg [1:NS-1];
    logic [127:0] rk_next [1:NS-1];
    logic [127:0] st_reg [NS];
    logic         v_reg [NS];
    logic         adv [NS];

    // hold the cipher key
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            key_reg <= '0;
        else if (cfg_we)
        begin
            case (cfg_index)
                aes_pkg::REG_KEY_HIGH: key_reg[127:64] <= cfg_data;
                aes_pkg::REG_KEY_LOW:  key_reg[63:0]   <= cfg_data;
                default: ;
            endcase
        end
    end

    // ripple round keys one stage per cycle, in step with the blocks while none stall
    always_comb
    begin
        rk_next[1] = aes_pkg::next_key(key_reg, aes_pkg::RCON[0]);
        for (int i = 2; i < NS; i++)
            rk_next[i] = aes_pkg::next_key(rk_reg[i-1], aes_pkg::RCON[i-1]);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 1; i < NS; i++)
            rk_reg[i] <= rk_next[i];
    end

    // stage advance: fill when empty or when downstream moves
    always_comb
    begin
        adv[NS-1] = !v_reg[NS-1] || !out_stall;
        for (int i = NS - 2; i >= 0; i--)
            adv[i] = !v_reg[i] || adv[i+1];
    end

    // advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
                v_reg[i] <= 1'b0;
        end
        else
        begin
            if (adv[0])
                v_reg[0] <= in_valid;
            for (int i = 1; i < NS; i++)
                if (adv[i])
                    v_reg[i] <= v_reg[i-1];
        end
    end

    // advance block state through the rounds
    always_ff @(posedge clk)
    begin
        if (adv[0])
            st_reg[0] <= {in_data.block_high, in_data.block_low} ^ key_reg;
        for (int i = 1; i < NS; i++)
            if (adv[i])
                st_reg[i] <= aes_pkg::enc_round(st_reg[i-1], rk_reg[i], i != NS - 1);
    end

    assign in_stall  = !adv[0];
    assign out_valid = v_reg[NS-1];
    assign out_data  = '{cipher_high: st_reg[NS-1][127:64], cipher_low: st_reg[NS-1][63:0]};

endmodule

@@ hdl/aes_checker.sv @@
// Port checker for the AES-128 encryption pipeline, bound to the top level.
// Depends on aes_pkg and aes128_block_encrypt.
module aes_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input aes_pkg::out_item_t out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // input stalls only behind a stalled full output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    // an empty output stage never blocks input
    a_empty_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while output empty");

    // an idle receiver never blocks input
    a_free_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output free");

endmodule

bind aes128_block_encrypt aes_checker u_aes_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

@@ tb/aes128_block_encrypt_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the AES-128 encryption pipeline: watches both channels,
// predicts each ciphertext from its own cipher model and compares. Uses aes_pkg.
module aes128_block_encrypt_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  aes_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  aes_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [63:0]        cfg_data,
    output int                 fail_count,
    output int                 pending
);

    logic [63:0]        key_hi_q, key_lo_q;
    aes_pkg::out_item_t cipher_q [$];

    assign pending = cipher_q.size();

    function automatic logic [7:0] xtime(input logic [7:0] x);
        xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // AES-128 encryption, bytes held in block order
    function automatic aes_pkg::out_item_t encrypt(input logic [127:0] key,
                                                   input logic [127:0] pt);
        logic [7:0] w [44][4];
        logic [7:0] st [16];
        logic [7:0] tmp [16];
        logic [7:0] tw [4];
        logic [7:0] rc, t0, a0, a1, a2, a3;
        logic [127:0] ct;
        aes_pkg::out_item_t res;
        rc = 8'h01;
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                w[i][j] = key[127 - 8*(4*i + j) -: 8];
        for (int i = 4; i < 44; i++)
        begin
            for (int j = 0; j < 4; j++)
                tw[j] = w[i-1][j];
            if (i % 4 == 0)
            begin
                t0 = tw[0];
                tw[0] = aes_pkg::SBOX[tw[1]] ^ rc;
                tw[1] = aes_pkg::SBOX[tw[2]];
                tw[2] = aes_pkg::SBOX[tw[3]];
                tw[3] = aes_pkg::SBOX[t0];
                rc = xtime(rc);
            end
            for (int j = 0; j < 4; j++)
                w[i][j] = w[i-4][j] ^ tw[j];
        end
        for (int i = 0; i < 16; i++)
            st[i] = pt[127 - 8*i -: 8] ^ w[i/4][i%4];
        for (int r = 1; r <= 10; r++)
        begin
            for (int c = 0; c < 4; c++)
                for (int q = 0; q < 4; q++)
                    tmp[4*c + q] = aes_pkg::SBOX[st[4*((c + q) % 4) + q]];
            if (r != 10)
                for (int c = 0; c < 4; c++)
                begin
                    a0 = tmp[4*c]; a1 = tmp[4*c+1]; a2 = tmp[4*c+2]; a3 = tmp[4*c+3];
                    tmp[4*c]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
                    tmp[4*c+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
                    tmp[4*c+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
                    tmp[4*c+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
                end
            for (int i = 0; i < 16; i++)
                st[i] = tmp[i] ^ w[4*r + i/4][i%4];
        end
        for (int i = 0; i < 16; i++)
            ct[127 - 8*i -: 8] = st[i];
        res.cipher_high = ct[127:64];
        res.cipher_low  = ct[63:0];
        return res;
    endfunction

    // track key writes, predict on input transactions, compare on output ones
    always @(posedge clk or negedge rst_n)
    begin
        aes_pkg::out_item_t want;
        int errs;
        if (!rst_n)
        begin
            key_hi_q   <= '0;
            key_lo_q   <= '0;
            fail_count <= 0;
            cipher_q.delete();
        end
        else
        begin
            errs = 0;
            if (cfg_we)
            begin
                if (cfg_index == aes_pkg::REG_KEY_HIGH)
                    key_hi_q <= cfg_data;
                else
                    key_lo_q <= cfg_data;
            end
            if (in_valid && !in_stall)
                cipher_q.insert(cipher_q.size(),
                                encrypt({key_hi_q, key_lo_q},
                                        {in_data.block_high, in_data.block_low}));
            if (out_valid && !out_stall)
            begin
                if (cipher_q.size() == 0)
                begin
                    $error("unexpected ciphertext %h", out_data);
                    errs++;
                end
                else
                begin
                    want = cipher_q.pop_front();
                    if (want.cipher_high !== out_data.cipher_high)
                    begin
                        $error("cipher_high expected %h actual %h",
                               want.cipher_high, out_data.cipher_high);
                        errs++;
                    end
                    if (want.cipher_low !== out_data.cipher_low)
                    begin
                        $error("cipher_low expected %h actual %h",
                               want.cipher_low, out_data.cipher_low);
                        errs++;
                    end
                end
            end
            if (errs != 0)
                fail_count <= fail_count + errs;
        end
    end
endmodule

@@ tb/aes128_block_encrypt_tb.sv @@
`timescale 1ns / 100ps
// Stimulus and verdict for the AES-128 encryption pipeline.
// Depends on aes_pkg, aes128_block_encrypt and aes128_block_encrypt_checker.
module aes128_block_encrypt_tb;

    localparam int LATENCY   = 10;
    localparam int MAX_CYCLE = 200000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    aes_pkg::in_item_t  in_data = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    aes_pkg::out_item_t out_data;
    logic               cfg_we = 1'b0;
    logic               cfg_index = aes_pkg::REG_KEY_HIGH;
    logic [63:0]        cfg_data = '0;
    int                 fail_count, pending;
    int                 cycle_count = 0;
    int                 hold_off = 0;
    bit                 stall_rand = 1'b0;

    aes128_block_encrypt dut (.*);
    aes128_block_encrypt_checker checker_i (.*);

    always #10 clk = ~clk;

    // abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver: random stall pattern, long hold-offs on request
    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off  <= hold_off - 1;
            out_stall <= 1'b1;
        end
        else if (stall_rand)
            out_stall <= ($urandom_range(0, 3) == 0);
        else
            out_stall <= 1'b0;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // offer one block and hold it until accepted
    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
        in_valid <= 1'b1;
        in_data  <= '{block_high: hi, block_low: lo};
        do @(posedge clk); while (in_stall);
    endtask

    task automatic idle_cycles(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic write_key(input logic [63:0] hi, input logic [63:0] lo);
        cfg_we <= 1'b1; cfg_index <= aes_pkg::REG_KEY_HIGH; cfg_data <= hi;
        @(posedge clk);
        cfg_index <= aes_pkg::REG_KEY_LOW; cfg_data <= lo;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // drain the pipeline before touching the key
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic random_phase(input int n);
        int burst;
        while (n > 0)
        begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && n > 0)
            begin
                send_block(rand64(), rand64());
                burst--; n--;
            end
            if ($urandom_range(0, 2) != 0)
                idle_cycles($urandom_range(1, 6));
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset key, extreme blocks
        send_block('0, '0);
        send_block('1, '1);
        send_block(64'h8000000000000000, 64'h0000000000000001);
        idle_cycles(1);
        drain();

        // standard test vector
        write_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
        send_block(64'h3243f6a8885a308d, 64'h313198a2e0370734);
        send_block(64'h00112233_44556677, 64'h8899aabb_ccddeeff);
        send_block('1, '0);
        drain();
        write_key('1, '1);
        send_block('0, '0);
        send_block('1, '1);
        send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
        drain();

        // long receiver hold-off while the sender keeps offering
        stall_rand <= 1'b1;
        write_key(rand64(), rand64());
        hold_off <= 60;
        random_phase(150);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            write_key(rand64(), rand64());
            if (ph == 2)
                hold_off <= 40;
            random_phase(180);
            drain();
        end

        // final phase without receiver stalls
        stall_rand <= 1'b0;
        write_key('0, '1);
        random_phase(100);
        drain();

        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
